>>> hw/rtl/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types, command codes, register indexes and saturation helper for the
// kernel composition convolver.
// ----------------------------------------------------------------------------
package kcc_pkg;

  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_QUERY       = 2'd2;

  localparam logic [2:0] CFG_FIRST_SIZE    = 3'd0;
  localparam logic [2:0] CFG_SECOND_SIZE   = 3'd1;
  localparam logic [2:0] CFG_FIRST_FACTOR  = 3'd2;
  localparam logic [2:0] CFG_FIRST_BIAS    = 3'd3;
  localparam logic [2:0] CFG_SECOND_FACTOR = 3'd4;
  localparam logic [2:0] CFG_SECOND_BIAS   = 3'd5;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] FACTOR_ONE = 32'sh0100_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [15:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] coefficient;
    logic               outside;
    logic [4:0]         composed_size;
    logic signed [31:0] composed_factor;
    logic signed [31:0] composed_bias;
  } out_t;

  typedef struct packed {
    logic [3:0]         first_size;
    logic [3:0]         second_size;
    logic signed [31:0] first_factor;
    logic signed [31:0] first_bias;
    logic signed [31:0] second_factor;
    logic signed [31:0] second_bias;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FACTOR,
    ST_BIAS,
    ST_CONV,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FACTOR,
    OP_BIAS,
    OP_COEF
  } op_t;

  function automatic logic signed [31:0] sat41(input logic signed [40:0] v);
    logic fits;
    fits = (&v[40:31]) | ~(|v[40:31]);
    if (fits) begin
      return v[31:0];
    end else if (v[40]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

>>> hw/rtl/kcc_store.sv
// ----------------------------------------------------------------------------
// kcc_store
// Coefficient memory for one kernel: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kcc_store #(
  parameter int DEPTH = 81
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [15:0]                             wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [15:0]                             rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/kcc_mul.sv
// ----------------------------------------------------------------------------
// kcc_mul
// Shared signed 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module kcc_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> hw/rtl/kcc_ctrl.sv
// ----------------------------------------------------------------------------
// kcc_ctrl
// Sequencer for loads and queries: walks the first kernel window, feeds the
// shared multiplier, accumulates and holds the result register.
// ----------------------------------------------------------------------------
module kcc_ctrl #(
  parameter int SIDE = 9
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  kcc_pkg::cfg_t                                 cfg,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  kcc_pkg::in_t                                  in_data,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output kcc_pkg::out_t                                 out_data,
  output logic                                          first_wr_en,
  output logic                                          second_wr_en,
  output logic [(SIDE*SIDE > 1 ? $clog2(SIDE*SIDE) : 1)-1:0] wr_addr,
  output logic [(SIDE*SIDE > 1 ? $clog2(SIDE*SIDE) : 1)-1:0] first_rd_addr,
  output logic [(SIDE*SIDE > 1 ? $clog2(SIDE*SIDE) : 1)-1:0] second_rd_addr,
  input  logic [15:0]                                   first_rd_data,
  input  logic [15:0]                                   second_rd_data,
  output logic signed [31:0]                            mul_a,
  output logic signed [31:0]                            mul_b,
  input  logic signed [63:0]                            mul_p
);

  import kcc_pkg::*;

  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int IW    = SIDE > 1 ? $clog2(SIDE) : 1;
  localparam int ACC_W = 32 + AW + 1;
  localparam logic [AW-1:0] SIDE_A = AW'(SIDE);
  localparam logic [4:0]    SIDE_5 = 5'(SIDE);

  state_t state, state_next;
  op_t    issue_op, tag1, tag2;

  logic [4:0] s1, s2, n;
  logic       accept, out_load, last_pos;
  logic       load_ok;

  logic [4:0] q_row, q_col;
  logic       q_outside;
  logic [IW-1:0] fi, fj;

  logic [5:0] dr, dc;
  logic       overlap;

  logic signed [31:0] opnd_a, opnd_b;
  logic signed [ACC_W-1:0] acc, acc_sh;
  logic [ACC_W-32:0]       acc_hi;
  logic signed [31:0]      coef_sat;
  logic signed [31:0]      cf, cb;

  // effective sizes
  always_comb begin
    priority if (cfg.first_size == 4'd0) begin
      s1 = 5'd1;
    end else if ({1'b0, cfg.first_size} > SIDE_5) begin
      s1 = SIDE_5;
    end else begin
      s1 = {1'b0, cfg.first_size};
    end
    priority if (cfg.second_size == 4'd0) begin
      s2 = 5'd1;
    end else if ({1'b0, cfg.second_size} > SIDE_5) begin
      s2 = SIDE_5;
    end else begin
      s2 = {1'b0, cfg.second_size};
    end
  end

  assign n      = s1 + s2 - 5'd1;
  assign accept = in_valid && !in_stall;

  // store writes on load transfers
  always_comb begin
    load_ok = 1'b0;
    if (in_data.cmd == CMD_LOAD_FIRST) begin
      load_ok = (in_data.row < s1) && (in_data.col < s1);
    end else if (in_data.cmd == CMD_LOAD_SECOND) begin
      load_ok = (in_data.row < s2) && (in_data.col < s2);
    end
  end

  assign first_wr_en  = accept && load_ok && (in_data.cmd == CMD_LOAD_FIRST);
  assign second_wr_en = accept && load_ok && (in_data.cmd == CMD_LOAD_SECOND);
  assign wr_addr      = AW'(in_data.row) * SIDE_A + AW'(in_data.col);

  // overlap window
  assign dr       = {1'b0, q_row} - 6'(fi);
  assign dc       = {1'b0, q_col} - 6'(fj);
  assign overlap  = !dr[5] && !dc[5] && (dr[4:0] < s2) && (dc[4:0] < s2);
  assign last_pos = (5'(fi) == s1 - 5'd1) && (5'(fj) == s1 - 5'd1);

  assign first_rd_addr  = AW'(fi) * SIDE_A + AW'(fj);
  assign second_rd_addr = overlap ? AW'(dr[4:0]) * SIDE_A + AW'(dc[4:0]) : '0;

  // multiplier operands
  always_comb begin
    if (tag1 == OP_COEF) begin
      mul_a = 32'(signed'(first_rd_data));
      mul_b = 32'(signed'(second_rd_data));
    end else begin
      mul_a = opnd_a;
      mul_b = opnd_b;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_data.cmd == CMD_QUERY) begin
          state_next = ST_FACTOR;
        end
      end
      ST_FACTOR: state_next = ST_BIAS;
      ST_BIAS:   state_next = q_outside ? ST_DRAIN : ST_CONV;
      ST_CONV: begin
        if (last_pos) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tag1 == OP_NONE && tag2 == OP_NONE) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    issue_op = OP_NONE;
    out_load = 1'b0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_FACTOR: issue_op = OP_FACTOR;
      ST_BIAS:   issue_op = OP_BIAS;
      ST_CONV:   issue_op = overlap ? OP_COEF : OP_NONE;
      ST_DRAIN:  issue_op = OP_NONE;
      ST_DONE:   out_load = !out_valid || !out_stall;
      default:   issue_op = OP_NONE;
    endcase
  end

  // result saturation
  assign acc_sh   = acc >>> 8;
  assign acc_hi   = acc_sh[ACC_W-1:31];
  assign coef_sat = ((&acc_hi) | ~(|acc_hi)) ? acc_sh[31:0]
                  : (acc_sh[ACC_W-1] ? SAT_MIN : SAT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tag1      <= OP_NONE;
      tag2      <= OP_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      tag1  <= issue_op;
      tag2  <= tag1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.cmd == CMD_QUERY) begin
      q_row     <= in_data.row;
      q_col     <= in_data.col;
      q_outside <= (in_data.row >= n) || (in_data.col >= n);
      fi        <= '0;
      fj        <= '0;
    end else if (state == ST_CONV) begin
      if (5'(fj) == s1 - 5'd1) begin
        fj <= '0;
        fi <= fi + IW'(1);
      end else begin
        fj <= fj + IW'(1);
      end
    end

    unique case (issue_op)
      OP_FACTOR: begin
        opnd_a <= cfg.first_factor;
        opnd_b <= cfg.second_factor;
      end
      OP_BIAS: begin
        opnd_a <= cfg.first_bias;
        opnd_b <= cfg.second_factor;
      end
      default: begin
        opnd_a <= opnd_a;
        opnd_b <= opnd_b;
      end
    endcase

    if (accept && in_data.cmd == CMD_QUERY) begin
      acc <= '0;
    end else begin
      unique case (tag2)
        OP_FACTOR: cf  <= sat41({mul_p[63], mul_p[63:24]});
        OP_BIAS:   cb  <= sat41({mul_p[63], mul_p[63:24]}
                                + {{9{cfg.second_bias[31]}}, cfg.second_bias});
        OP_COEF:   acc <= acc + mul_p[ACC_W-1:0];
        default:   acc <= acc;
      endcase
    end

    if (out_load) begin
      out_data.coefficient     <= q_outside ? 32'sd0 : coef_sat;
      out_data.outside         <= q_outside;
      out_data.composed_size   <= n;
      out_data.composed_factor <= cf;
      out_data.composed_bias   <= cb;
    end
  end

endmodule

>>> hw/rtl/kernel_composition_convolver.sv
// ----------------------------------------------------------------------------
// kernel_composition_convolver
// Composes two square Q7.8 kernels by full 2D convolution, one queried
// coefficient at a time, with composed factor and bias.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall/in_data) carries load and query
// items; the output channel (out_valid/out_stall/out_data) returns one result
// per query. Configuration registers are written through cfg_wr_en, cfg_index
// and cfg_data while the block is idle.
// A load gives no result. A query holds in_stall high until its result is
// loaded: factor and bias are computed first, then the first kernel window is
// walked one position per cycle; each position overlapping the second kernel
// sends one product through the shared 32x32 multiplier (no walk for a query
// outside the composed kernel); the multiplier pipeline then drains.
// The result register lets the next item be taken while a result waits; a
// query that finishes while out_stall holds a previous result waits until
// that transfer completes.
// Reset clears the sequencer and output valid and restores the register
// defaults; kernel memories are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module kernel_composition_convolver #(
  parameter int MAX_KERNEL_SIDE = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  kcc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output kcc_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  import kcc_pkg::*;

  localparam int DEPTH = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  cfg_t cfg;

  logic          first_wr_en, second_wr_en;
  logic [AW-1:0] wr_addr, first_rd_addr, second_rd_addr;
  logic [15:0]   first_rd_data, second_rd_data;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_size    <= 4'd1;
      cfg.second_size   <= 4'd1;
      cfg.first_factor  <= FACTOR_ONE;
      cfg.first_bias    <= 32'sd0;
      cfg.second_factor <= FACTOR_ONE;
      cfg.second_bias   <= 32'sd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FIRST_SIZE:    cfg.first_size    <= cfg_data[3:0];
        CFG_SECOND_SIZE:   cfg.second_size   <= cfg_data[3:0];
        CFG_FIRST_FACTOR:  cfg.first_factor  <= cfg_data;
        CFG_FIRST_BIAS:    cfg.first_bias    <= cfg_data;
        CFG_SECOND_FACTOR: cfg.second_factor <= cfg_data;
        CFG_SECOND_BIAS:   cfg.second_bias   <= cfg_data;
        default:           cfg <= cfg;
      endcase
    end
  end

  kcc_store #(.DEPTH(DEPTH)) u_first_store (
    .clk     (clk),
    .wr_en   (first_wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_addr (first_rd_addr),
    .rd_data (first_rd_data)
  );

  kcc_store #(.DEPTH(DEPTH)) u_second_store (
    .clk     (clk),
    .wr_en   (second_wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_addr (second_rd_addr),
    .rd_data (second_rd_data)
  );

  kcc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  kcc_ctrl #(.SIDE(MAX_KERNEL_SIDE)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .first_wr_en    (first_wr_en),
    .second_wr_en   (second_wr_en),
    .wr_addr        (wr_addr),
    .first_rd_addr  (first_rd_addr),
    .second_rd_addr (second_rd_addr),
    .first_rd_data  (first_rd_data),
    .second_rd_data (second_rd_data),
    .mul_a          (mul_a),
    .mul_b          (mul_b),
    .mul_p          (mul_p)
  );

endmodule
